### hdl/swmm_pkg.sv
// Package for the sliding-window minimum/maximum block.
// Holds default sizes, the register width, the deque sequencer states and the
// control word that the top level hands to each deque unit. Depends on nothing.
package swmm_pkg;

  localparam int WINDOW_MAX_DEF   = 64;
  localparam int SAMPLE_WIDTH_DEF = 32;

  // Width and reset value of the window_size register.
  localparam int CFG_WIDTH = 7;
  localparam logic [CFG_WIDTH-1:0] WINDOW_SIZE_RST = CFG_WIDTH'(1);

  typedef enum logic [1:0] {
    DQ_IDLE,
    DQ_FRONT,
    DQ_BACK,
    DQ_DONE
  } dq_state_t;

  typedef struct packed {
    logic go;     // start one word; sample, position and window are valid
    logic clear;  // empty the deque before this word
    logic ack;    // result has been taken
  } dq_ctrl_t;

endpackage

### hdl/swmm_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the deque rings of the sliding-window block. No dependencies.
module swmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/swmm_deque.sv
// One monotonic deque kept as a ring in a RAM, with its sequencer.
// Depends on swmm_pkg (states, control word) and swmm_ram.
module swmm_deque #(
  parameter int WINDOW_MAX   = swmm_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = swmm_pkg::SAMPLE_WIDTH_DEF,
  parameter bit KEEP_MIN     = 1'b1
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  swmm_pkg::dq_ctrl_t                    ctrl,
  input  logic [SAMPLE_WIDTH-1:0]               sample,
  input  logic [$clog2(2*WINDOW_MAX)-1:0]       pos,
  input  logic [$clog2(WINDOW_MAX+1)-1:0]       win,
  output logic                                  done,
  output logic [SAMPLE_WIDTH-1:0]               result
);

  localparam int POS_MOD = 2 * WINDOW_MAX;
  localparam int POS_W   = $clog2(POS_MOD);
  localparam int CNT_W   = $clog2(WINDOW_MAX + 1);
  localparam int AW      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int SUM_W   = CNT_W + 1;
  localparam int ENT_W   = SAMPLE_WIDTH + POS_W;

  swmm_pkg::dq_state_t state_r, state_nxt;
  logic [AW-1:0]           h_r, h_nxt;
  logic [CNT_W-1:0]        c_r, c_nxt;
  logic [SAMPLE_WIDTH-1:0] sample_r, sample_nxt;
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic [CNT_W-1:0]        win_r, win_nxt;
  logic [SAMPLE_WIDTH-1:0] front_r, front_nxt;
  logic [SAMPLE_WIDTH-1:0] res_r, res_nxt;

  logic                    we;
  logic [AW-1:0]           wr_addr;
  logic [ENT_W-1:0]        wr_data;
  logic [AW-1:0]           rd_addr;
  logic [ENT_W-1:0]        rd_data;
  logic [SAMPLE_WIDTH-1:0] rd_val;
  logic [POS_W-1:0]        rd_pos;
  logic [POS_W-1:0]        age;
  logic                    expired;
  logic                    dominated;
  logic [AW-1:0]           h_inc;

  // Ring slot h + k, with k at most WINDOW_MAX.
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] h,
                                             input logic [CNT_W-1:0] k);
    logic [SUM_W-1:0] s;
    s = SUM_W'(h) + SUM_W'(k);
    if (s >= SUM_W'(WINDOW_MAX)) begin
      s = s - SUM_W'(WINDOW_MAX);
    end
    return AW'(s);
  endfunction

  swmm_ram #(
    .WIDTH (ENT_W),
    .DEPTH (WINDOW_MAX)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign rd_val = rd_data[SAMPLE_WIDTH-1:0];
  assign rd_pos = rd_data[ENT_W-1:SAMPLE_WIDTH];

  // Positions wrap at twice the window limit; the age is the modular distance.
  always_comb begin
    if (pos_r >= rd_pos) begin
      age = pos_r - rd_pos;
    end else begin
      age = pos_r - rd_pos + POS_W'(POS_MOD);
    end
  end

  assign expired = (age >= POS_W'(win_r));
  assign dominated = KEEP_MIN ? ($signed(sample_r) <= $signed(rd_val))
                              : ($signed(sample_r) >= $signed(rd_val));
  assign h_inc = ring_add(h_r, CNT_W'(1));

  always_comb begin
    state_nxt  = state_r;
    h_nxt      = h_r;
    c_nxt      = c_r;
    sample_nxt = sample_r;
    pos_nxt    = pos_r;
    win_nxt    = win_r;
    front_nxt  = front_r;
    res_nxt    = res_r;
    we         = 1'b0;
    wr_addr    = h_r;
    wr_data    = {pos_r, sample_r};
    rd_addr    = h_r;

    if (ctrl.go) begin
      sample_nxt = sample;
      pos_nxt    = pos;
      win_nxt    = win;
      if (ctrl.clear || (c_r == '0)) begin
        // Empty deque: the new sample is the whole deque and its extreme.
        h_nxt     = ctrl.clear ? '0 : h_r;
        we        = 1'b1;
        wr_addr   = h_nxt;
        wr_data   = {pos, sample};
        c_nxt     = CNT_W'(1);
        res_nxt   = sample;
        state_nxt = swmm_pkg::DQ_DONE;
      end else begin
        rd_addr   = h_r;
        state_nxt = swmm_pkg::DQ_FRONT;
      end
    end else begin
      unique case (state_r)
        swmm_pkg::DQ_IDLE: begin
        end
        swmm_pkg::DQ_FRONT: begin
          if (expired) begin
            h_nxt = h_inc;
            c_nxt = c_r - CNT_W'(1);
            if (c_r == CNT_W'(1)) begin
              we        = 1'b1;
              wr_addr   = h_inc;
              c_nxt     = CNT_W'(1);
              res_nxt   = sample_r;
              state_nxt = swmm_pkg::DQ_DONE;
            end else begin
              rd_addr = h_inc;
            end
          end else begin
            // This entry stays at the front unless the back scan empties the deque.
            front_nxt = rd_val;
            rd_addr   = ring_add(h_r, c_r - CNT_W'(1));
            state_nxt = swmm_pkg::DQ_BACK;
          end
        end
        swmm_pkg::DQ_BACK: begin
          if (dominated) begin
            c_nxt = c_r - CNT_W'(1);
            if (c_r == CNT_W'(1)) begin
              we        = 1'b1;
              wr_addr   = h_r;
              c_nxt     = CNT_W'(1);
              res_nxt   = sample_r;
              state_nxt = swmm_pkg::DQ_DONE;
            end else begin
              rd_addr = ring_add(h_r, c_r - CNT_W'(2));
            end
          end else begin
            we        = 1'b1;
            wr_addr   = ring_add(h_r, c_r);
            c_nxt     = c_r + CNT_W'(1);
            res_nxt   = front_r;
            state_nxt = swmm_pkg::DQ_DONE;
          end
        end
        swmm_pkg::DQ_DONE: begin
          if (ctrl.ack) begin
            state_nxt = swmm_pkg::DQ_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= swmm_pkg::DQ_IDLE;
      h_r     <= '0;
      c_r     <= '0;
    end else begin
      state_r <= state_nxt;
      h_r     <= h_nxt;
      c_r     <= c_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r <= sample_nxt;
    pos_r    <= pos_nxt;
    win_r    <= win_nxt;
    front_r  <= front_nxt;
    res_r    <= res_nxt;
  end

  assign done   = (state_r == swmm_pkg::DQ_DONE);
  assign result = res_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    c_r <= CNT_W'(WINDOW_MAX))
    else $error("deque count above window limit");

  a_go_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.go |-> (state_r == swmm_pkg::DQ_IDLE || state_r == swmm_pkg::DQ_DONE))
    else $error("new word started while deque busy");

  a_busy_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == swmm_pkg::DQ_FRONT || state_r == swmm_pkg::DQ_BACK ||
     state_r == swmm_pkg::DQ_DONE) |-> (c_r != '0))
    else $error("deque empty while scanning or after a push");

  a_ack_in_done: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.ack |-> (state_r == swmm_pkg::DQ_DONE))
    else $error("result taken before deque finished");

  a_push_finishes: assert property (@(posedge clk) disable iff (!rst_n)
    we |=> (state_r == swmm_pkg::DQ_DONE))
    else $error("push without finishing the word");
`endif

endmodule

### hdl/sliding_window_min_max.sv
// Top level of the sliding-window minimum/maximum block.
// Depends on swmm_pkg and swmm_deque (which instantiates swmm_ram).
//
//   channel | ports                                     | transfer
//   --------+-------------------------------------------+---------------------
//   input   | in_valid, in_ready, in_sample,            | valid & ready
//           | in_start_of_sequence                      |
//   result  | out_valid, out_ready, out_window_min/max  | valid & ready
//   config  | cfg_we, cfg_wdata (window_size)           | cfg_we, no wait
//
// A word goes from acceptance through DQ_FRONT and DQ_BACK to DQ_DONE, where the next
// word can be accepted, when nothing expires and nothing is dominated, and straight
// to DQ_DONE when both deques are empty. Each entry popped from a deque adds a step,
// except the one that empties it, which ends the scan at once; each step is one read
// of that deque's RAM (registered read). The slower of the two deques sets the time.
// Reset is synchronous; it empties both deques and needs no clearing pass.
// A word waiting in the output register does not stop the next word from entering;
// the following result waits only if that register is still full.
module sliding_window_min_max #(
  parameter int WINDOW_MAX   = swmm_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = swmm_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [swmm_pkg::CFG_WIDTH-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [SAMPLE_WIDTH-1:0]        in_sample,
  input  logic                           in_start_of_sequence,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [SAMPLE_WIDTH-1:0]        out_window_min,
  output logic [SAMPLE_WIDTH-1:0]        out_window_max
);

  localparam int POS_MOD = 2 * WINDOW_MAX;
  localparam int POS_W   = $clog2(POS_MOD);
  localparam int CNT_W   = $clog2(WINDOW_MAX + 1);
  localparam int CMP_W   = (swmm_pkg::CFG_WIDTH > CNT_W) ? swmm_pkg::CFG_WIDTH : CNT_W;

  logic [swmm_pkg::CFG_WIDTH-1:0] window_size_r;
  logic [CMP_W-1:0]  cfg_ext;
  logic [CMP_W-1:0]  win_clamp;
  logic [CNT_W-1:0]  win;

  logic [POS_W-1:0]  pos_r, pos_nxt, base_pos;
  logic [CNT_W-1:0]  fill_r, fill_nxt, base_fill;
  logic              busy_r, busy_nxt;
  logic              emit_r, emit_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [SAMPLE_WIDTH-1:0] out_min_r, out_max_r;

  logic              accept;
  logic              collect;
  logic              min_done, max_done;
  logic [SAMPLE_WIDTH-1:0] min_res, max_res;
  swmm_pkg::dq_ctrl_t ctrl;

  // Window size zero acts as one; sizes beyond the limit act as the limit.
  assign cfg_ext = CMP_W'(window_size_r);
  always_comb begin
    if (cfg_ext == '0) begin
      win_clamp = CMP_W'(1);
    end else if (cfg_ext > CMP_W'(WINDOW_MAX)) begin
      win_clamp = CMP_W'(WINDOW_MAX);
    end else begin
      win_clamp = cfg_ext;
    end
  end
  assign win = CNT_W'(win_clamp);

  assign collect  = busy_r && min_done && max_done && (!out_valid_r || out_ready);
  assign in_ready = !busy_r || collect;
  assign accept   = in_valid && in_ready;

  assign ctrl.go    = accept;
  assign ctrl.clear = in_start_of_sequence;
  assign ctrl.ack   = collect;

  assign base_pos  = in_start_of_sequence ? '0 : pos_r;
  assign base_fill = in_start_of_sequence ? '0 : fill_r;

  always_comb begin
    pos_nxt       = pos_r;
    fill_nxt      = fill_r;
    emit_nxt      = emit_r;
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r;

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (collect) begin
      busy_nxt = 1'b0;
      if (emit_r) begin
        out_valid_nxt = 1'b1;
      end
    end
    if (accept) begin
      busy_nxt = 1'b1;
      pos_nxt  = (base_pos == POS_W'(POS_MOD - 1)) ? '0 : base_pos + POS_W'(1);
      fill_nxt = (base_fill == CNT_W'(WINDOW_MAX)) ? base_fill : base_fill + CNT_W'(1);
      emit_nxt = (fill_nxt >= win);
    end
  end

  swmm_deque #(
    .WINDOW_MAX   (WINDOW_MAX),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .KEEP_MIN     (1'b1)
  ) u_min (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .sample (in_sample),
    .pos    (base_pos),
    .win    (win),
    .done   (min_done),
    .result (min_res)
  );

  swmm_deque #(
    .WINDOW_MAX   (WINDOW_MAX),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .KEEP_MIN     (1'b0)
  ) u_max (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .sample (in_sample),
    .pos    (base_pos),
    .win    (win),
    .done   (max_done),
    .result (max_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= swmm_pkg::WINDOW_SIZE_RST;
      pos_r         <= '0;
      fill_r        <= '0;
      busy_r        <= 1'b0;
      emit_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        window_size_r <= cfg_wdata;
      end
      pos_r       <= pos_nxt;
      fill_r      <= fill_nxt;
      busy_r      <= busy_nxt;
      emit_r      <= emit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (collect && emit_r) begin
      out_min_r <= min_res;
      out_max_r <= max_res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_window_min = out_min_r;
  assign out_window_max = out_max_r;

endmodule
